### rtl/rthit_pkg.sv
`default_nettype none

package rthit_pkg;

  // Command codes on the input channel
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Status codes on the output channel
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Sequencer step addresses
  localparam int STEP_W = 2;
  localparam logic [STEP_W-1:0] STEP_IDLE  = 2'd0;
  localparam logic [STEP_W-1:0] STEP_ROUTE = 2'd1;
  localparam logic [STEP_W-1:0] STEP_SCAN  = 2'd2;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 2'd3;

  // Jump conditions; a jump is taken when its condition is true,
  // otherwise the step counter advances (and wraps after the last step)
  localparam int COND_W = 2;
  localparam logic [COND_W-1:0] COND_WAIT_IN   = 2'd0;
  localparam logic [COND_W-1:0] COND_IS_ADD    = 2'd1;
  localparam logic [COND_W-1:0] COND_SCAN_MORE = 2'd2;
  localparam logic [COND_W-1:0] COND_OUT_BUSY  = 2'd3;

  // One control word of the microprogram
  typedef struct packed {
    logic              ready;  // take an input word this step
    logic              add;    // append rectangle when command is add
    logic              scan;   // issue one table read, compare previous
    logic              emit;   // hand result to the output register
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // Status flags the sequencer branches on
  typedef struct packed {
    logic accept;
    logic is_add;
    logic scan_more;
    logic out_busy;
  } flags_t;

  // One stored rectangle
  typedef struct packed {
    logic [14:0] sheet;
    logic [13:0] col_start;
    logic [13:0] col_end;
    logic [19:0] row_start;
    logic [19:0] row_end;
  } entry_t;

endpackage

`default_nettype wire

### rtl/rectangle_table_point_hit_test.sv
// Channel | Handshake          | Word
// --------+--------------------+------------------------------------------------
// in      | in_valid, in_stall | command, sheet_number, first/last_column,
//         |                    | first/last_row, point_column, point_row
// out     | out_valid,out_stall| hit, status
//
// An add word steps the sequencer through idle, route and emit, and a query
// through idle, route, scan and emit, reading one stored rectangle per cycle in
// the scan step; the result is in the output register after the last of them.
// A new word is taken only in the idle step, even while a result waits on a
// stalled output, which then holds the next result in the emit step.
// Reset clears the step counter, entry count and output valid, not the table.
`default_nettype none

module rectangle_table_point_hit_test
  import rthit_pkg::*;
#(
  parameter int MAX_AREAS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic        command,
  input  wire logic [14:0] sheet_number,
  input  wire logic [13:0] first_column,
  input  wire logic [13:0] last_column,
  input  wire logic [19:0] first_row,
  input  wire logic [19:0] last_row,
  input  wire logic [13:0] point_column,
  input  wire logic [19:0] point_row,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        hit,
  output      logic        status
);

  // Index width addresses the table; count width also holds MAX_AREAS itself
  localparam int IW = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
  localparam int CW = $clog2(MAX_AREAS + 1);

  ctrl_t  ctrl;
  flags_t flags;

  // Latched input word
  logic        q_command;
  logic [14:0] q_sheet;
  logic [13:0] q_point_column;
  logic [19:0] q_point_row;
  entry_t      q_entry;

  // Table and scan datapath
  entry_t          table_mem [MAX_AREAS];
  entry_t          rd_data;
  logic            rd_valid;
  logic [CW-1:0]   count;
  logic [CW-1:0]   idx;
  logic            full;
  logic            more;
  logic            match;
  logic            hit_acc;
  logic            status_acc;
  logic            accept;

  rthit_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign in_stall = !ctrl.ready;
  assign accept   = in_valid && ctrl.ready;
  assign full     = (count == CW'(MAX_AREAS));
  assign more     = (idx < count);

  assign flags.accept    = accept;
  assign flags.is_add    = (q_command == CMD_ADD);
  assign flags.scan_more = more;
  assign flags.out_busy  = out_valid && out_stall;

  // Compare the entry read in the previous cycle against the query point
  assign match = rd_valid && (rd_data.sheet == q_sheet) &&
                 (q_point_column >= rd_data.col_start) &&
                 (q_point_column <= rd_data.col_end) &&
                 (q_point_row >= rd_data.row_start) &&
                 (q_point_row <= rd_data.row_end);

  // Hold the accepted word for the whole operation
  always_ff @(posedge clk) begin
    if (accept) begin
      q_command         <= command;
      q_sheet           <= sheet_number;
      q_point_column    <= point_column;
      q_point_row       <= point_row;
      q_entry.sheet     <= sheet_number;
      q_entry.col_start <= first_column;
      q_entry.col_end   <= last_column;
      q_entry.row_start <= first_row;
      q_entry.row_end   <= last_row;
    end
  end

  // Append a rectangle at the fill point, read one entry per scan step
  always_ff @(posedge clk) begin
    if (ctrl.add && q_command == CMD_ADD && !full) begin
      table_mem[count[IW-1:0]] <= q_entry;
    end
    if (ctrl.scan && more) begin
      rd_data <= table_mem[idx[IW-1:0]];
    end
  end

  // Entry count, scan index and the result being built
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      idx        <= '0;
      rd_valid   <= 1'b0;
      hit_acc    <= 1'b0;
      status_acc <= STATUS_OK;
    end else begin
      if (accept) begin
        idx        <= '0;
        rd_valid   <= 1'b0;
        hit_acc    <= 1'b0;
        status_acc <= STATUS_OK;
      end
      if (ctrl.add && q_command == CMD_ADD) begin
        if (full) begin
          status_acc <= STATUS_FULL;
        end else begin
          count <= count + 1'b1;
        end
      end
      if (ctrl.scan) begin
        // Advance while entries remain; the last compare drains on the exit step
        rd_valid <= more;
        if (more) begin
          idx <= idx + 1'b1;
        end
        if (match) begin
          hit_acc <= 1'b1;
        end
      end
    end
  end

  // Output register: load when the slot is free or being drained this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit && !flags.out_busy) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit && !flags.out_busy) begin
      hit    <= hit_acc;
      status <= status_acc;
    end
  end

endmodule

`default_nettype wire

### rtl/rthit_seq.sv
`default_nettype none

module rthit_seq
  import rthit_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire flags_t flags,
  output ctrl_t       ctrl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              taken;

  // Microprogram ROM
  always_comb begin
    case (step)
      STEP_IDLE: begin
        ctrl = '{ready: 1'b1, add: 1'b0, scan: 1'b0, emit: 1'b0,
                 cond: COND_WAIT_IN, target: STEP_IDLE};
      end
      STEP_ROUTE: begin
        ctrl = '{ready: 1'b0, add: 1'b1, scan: 1'b0, emit: 1'b0,
                 cond: COND_IS_ADD, target: STEP_EMIT};
      end
      STEP_SCAN: begin
        ctrl = '{ready: 1'b0, add: 1'b0, scan: 1'b1, emit: 1'b0,
                 cond: COND_SCAN_MORE, target: STEP_SCAN};
      end
      STEP_EMIT: begin
        ctrl = '{ready: 1'b0, add: 1'b0, scan: 1'b0, emit: 1'b1,
                 cond: COND_OUT_BUSY, target: STEP_EMIT};
      end
      default: begin
        ctrl = '{ready: 1'b0, add: 1'b0, scan: 1'b0, emit: 1'b0,
                 cond: COND_WAIT_IN, target: STEP_IDLE};
      end
    endcase
  end

  always_comb begin
    case (ctrl.cond)
      COND_WAIT_IN:   taken = !flags.accept;
      COND_IS_ADD:    taken = flags.is_add;
      COND_SCAN_MORE: taken = flags.scan_more;
      COND_OUT_BUSY:  taken = flags.out_busy;
      default:        taken = 1'b0;
    endcase
  end

  // Jump or advance; the last step wraps back to idle
  assign step_next = taken ? ctrl.target : step + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

### rtl/rthit_chk.sv
`default_nettype none

module rthit_chk (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic hit,
  input wire logic status
);

  // A stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result does not change
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(hit) && $stable(status))
    else $error("result changed while stalled");

  // A refused add never reports a hit
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !hit)
    else $error("hit reported with table-full status");

  // After taking a word the block is busy on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken back to back");

  // Reset empties the output
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind rectangle_table_point_hit_test rthit_chk u_rthit_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .hit       (hit),
  .status    (status)
);

`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none

// Rectangle table / point hit test: directed table, then long random traffic.
module testbench;
  import rthit_pkg::*;

  localparam int AREA_LIMIT = 64;
  localparam logic [14:0] SHEET_MAX = 15'h7FFF;
  localparam logic [13:0] COL_MAX = 14'h3FFF;
  localparam logic [19:0] ROW_MAX = 20'hFFFFF;
  localparam int NUM_DIRECTED = 23;
  localparam int NUM_RANDOM = 1530;
  // A query scans every stored rectangle; allow the full table plus margin.
  localparam int DRAIN_CYCLES = AREA_LIMIT + 20;
  localparam int PRESSURE_CYCLES = 400;

  // One input word, plus an optional expected answer typed in by hand.
  typedef struct packed {
    logic        cmd;
    logic [14:0] sheet;
    logic [13:0] col_lo;
    logic [13:0] col_hi;
    logic [19:0] row_lo;
    logic [19:0] row_hi;
    logic [13:0] pt_col;
    logic [19:0] pt_row;
    logic        typed;
    logic        hit;
    logic        status;
  } rect_word_t;

  typedef struct packed {
    logic hit;
    logic status;
  } answer_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        command;
  logic [14:0] sheet_number;
  logic [13:0] first_column;
  logic [13:0] last_column;
  logic [19:0] first_row;
  logic [19:0] last_row;
  logic [13:0] point_column;
  logic [19:0] point_row;
  logic        out_valid;
  logic        out_stall;
  logic        hit;
  logic        status;

  // Shadow copy of the rectangle table, updated as each word is accepted.
  int          stored_count;
  logic [14:0] stored_sheet   [AREA_LIMIT];
  logic [13:0] stored_col_lo  [AREA_LIMIT];
  logic [13:0] stored_col_hi  [AREA_LIMIT];
  logic [19:0] stored_row_lo  [AREA_LIMIT];
  logic [19:0] stored_row_hi  [AREA_LIMIT];

  answer_t     pending_answers [$];
  answer_t     oldest;
  rect_word_t  directed_words [NUM_DIRECTED];
  logic [14:0] sheet_pool [4];
  int          mismatch_count;
  int          results_seen;
  int          words_accepted;
  int          send_quiet_left;
  int          hold_left;
  logic        hold_value;
  logic        pressure_done;

  rectangle_table_point_hit_test #(
    .MAX_AREAS(AREA_LIMIT)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .sheet_number(sheet_number),
    .first_column(first_column),
    .last_column(last_column),
    .first_row(first_row),
    .last_row(last_row),
    .point_column(point_column),
    .point_row(point_row),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hit(hit),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard ceiling on the run: far above the slowest legal run
  // (every word a full 64-entry scan, plus the longest gaps and stalls).
  initial begin
    #1600000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic got, input logic want);
    $display("mismatch at result %0d: %s got %b want %b", results_seen, what, got, want);
    mismatch_count++;
  endtask

  // Apply one word to the shadow table and work out its answer.
  function automatic void lookup_rectangles(input rect_word_t w, output logic found,
                                            output logic refused);
    found = 1'b0;
    refused = STATUS_OK;
    if (w.cmd == CMD_ADD) begin
      if (stored_count >= AREA_LIMIT) begin
        refused = STATUS_FULL;
      end else begin
        stored_sheet[stored_count]  = w.sheet;
        stored_col_lo[stored_count] = w.col_lo;
        stored_col_hi[stored_count] = w.col_hi;
        stored_row_lo[stored_count] = w.row_lo;
        stored_row_hi[stored_count] = w.row_hi;
        stored_count++;
      end
    end else begin
      // An inverted range fails one of the two bounds, so it never matches.
      for (int i = 0; i < stored_count; i++) begin
        if (stored_sheet[i] == w.sheet &&
            w.pt_col >= stored_col_lo[i] && w.pt_col <= stored_col_hi[i] &&
            w.pt_row >= stored_row_lo[i] && w.pt_row <= stored_row_hi[i])
          found = 1'b1;
      end
    end
  endfunction

  // Most gaps are zero or short, a few long; now and then a burst with none.
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (send_quiet_left > 0) begin
      send_quiet_left--;
      return 0;
    end
    if (r < 50) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 10);
    if (r < 97) return $urandom_range(15, 40);
    send_quiet_left = $urandom_range(20, 60);
    return 0;
  endfunction

  // Aim one coordinate at a stored range: an end, just past an end, or between.
  function automatic int aim(input int lo, input int hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      2: return lo - 1;
      3: return hi + 1;
      default: return (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic logic [14:0] pick_sheet();
    if ($urandom_range(0, 9) < 8) return sheet_pool[$urandom_range(0, 3)];
    return 15'($urandom);
  endfunction

  function automatic rect_word_t random_word();
    rect_word_t w;
    int kind;
    int k;
    int stretch;
    // Fields the command ignores carry random noise.
    w.cmd    = ($urandom_range(0, 11) == 0) ? CMD_ADD : CMD_QUERY;
    w.sheet  = pick_sheet();
    w.col_lo = 14'($urandom);
    w.col_hi = 14'($urandom);
    w.row_lo = 20'($urandom);
    w.row_hi = 20'($urandom);
    w.pt_col = 14'($urandom);
    w.pt_row = 20'($urandom);
    w.typed  = 1'b0;
    w.hit    = 1'b0;
    w.status = STATUS_OK;
    kind = $urandom_range(0, 99);
    if (w.cmd == CMD_ADD) begin
      if (kind < 15) begin
        // keep fully random corners, often inverted
      end else if (kind < 22) begin
        w.col_hi = w.col_lo - 14'($urandom_range(1, 50));
      end else if (kind < 29) begin
        w.row_hi = w.row_lo - 20'($urandom_range(1, 500));
      end else begin
        stretch = int'(w.col_lo) + $urandom_range(0, 400);
        w.col_hi = (stretch > int'(COL_MAX)) ? COL_MAX : 14'(stretch);
        stretch = int'(w.row_lo) + $urandom_range(0, 20000);
        w.row_hi = (stretch > int'(ROW_MAX)) ? ROW_MAX : 20'(stretch);
      end
    end else if (stored_count > 0 && kind < 65) begin
      // Target a stored rectangle so that hits and near misses are common.
      k = $urandom_range(0, stored_count - 1);
      w.sheet  = stored_sheet[k];
      w.pt_col = 14'(aim(int'(stored_col_lo[k]), int'(stored_col_hi[k])));
      w.pt_row = 20'(aim(int'(stored_row_lo[k]), int'(stored_row_hi[k])));
    end
    return w;
  endfunction

  // Offer one word after a random gap, hold it until taken, then predict it.
  task automatic offer_word(input rect_word_t w);
    logic    want_hit;
    logic    want_status;
    answer_t ans;
    int      gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    command      <= w.cmd;
    sheet_number <= w.sheet;
    first_column <= w.col_lo;
    last_column  <= w.col_hi;
    first_row    <= w.row_lo;
    last_row     <= w.row_hi;
    point_column <= w.pt_col;
    point_row    <= w.pt_row;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall);
    lookup_rectangles(w, want_hit, want_status);
    // Rows with a typed answer use it; the shadow table still advances.
    ans.hit    = w.typed ? w.hit : want_hit;
    ans.status = w.typed ? w.status : want_status;
    pending_answers.insert(pending_answers.size(), ans);
    words_accepted++;
    @(negedge clk);
  endtask

  // Sender: reset, directed table, random traffic, drain, verdict.
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_ADD;
    sheet_number = '0;
    first_column = '0;
    last_column = '0;
    first_row = '0;
    last_row = '0;
    point_column = '0;
    point_row = '0;
    stored_count = 0;
    mismatch_count = 0;
    results_seen = 0;
    words_accepted = 0;
    send_quiet_left = 0;
    sheet_pool[0] = '0;
    sheet_pool[1] = SHEET_MAX;
    sheet_pool[2] = 15'($urandom);
    sheet_pool[3] = 15'($urandom_range(1, 8));

    // cmd, sheet, col_lo, col_hi, row_lo, row_hi, pt_col, pt_row, typed, hit, status
    directed_words = '{
      // empty table: no hit anywhere
      '{CMD_QUERY, 15'd0, 14'd0, 14'd0, 20'd0, 20'd0, 14'd0, 20'd0, 1'b1, 1'b0, STATUS_OK},
      '{CMD_QUERY, SHEET_MAX, 14'd0, 14'd0, 20'd0, 20'd0, COL_MAX, ROW_MAX,
        1'b1, 1'b0, STATUS_OK},
      // whole-sheet rectangle, hit at both far corners, other sheet misses
      '{CMD_ADD, 15'd0, 14'd0, COL_MAX, 20'd0, ROW_MAX, 14'd0, 20'd0, 1'b1, 1'b0, STATUS_OK},
      '{CMD_QUERY, 15'd0, 14'd0, 14'd0, 20'd0, 20'd0, COL_MAX, ROW_MAX,
        1'b1, 1'b1, STATUS_OK},
      '{CMD_QUERY, 15'd0, 14'd0, 14'd0, 20'd0, 20'd0, 14'd0, 20'd0, 1'b1, 1'b1, STATUS_OK},
      '{CMD_QUERY, 15'd1, 14'd0, 14'd0, 20'd0, 20'd0, 14'd5, 20'd5, 1'b1, 1'b0, STATUS_OK},
      // bounded rectangle: inclusive ends hit, one step outside misses
      '{CMD_ADD, SHEET_MAX, 14'd100, 14'd200, 20'd1000, 20'd2000, 14'd0, 20'd0,
        1'b1, 1'b0, STATUS_OK},
      '{CMD_QUERY, SHEET_MAX, 14'd0, 14'd0, 20'd0, 20'd0, 14'd100, 20'd1000,
        1'b1, 1'b1, STATUS_OK},
      '{CMD_QUERY, SHEET_MAX, 14'd0, 14'd0, 20'd0, 20'd0, 14'd200, 20'd2000,
        1'b1, 1'b1, STATUS_OK},
      '{CMD_QUERY, SHEET_MAX, 14'd0, 14'd0, 20'd0, 20'd0, 14'd99, 20'd1500,
        1'b1, 1'b0, STATUS_OK},
      '{CMD_QUERY, SHEET_MAX, 14'd0, 14'd0, 20'd0, 20'd0, 14'd201, 20'd1500,
        1'b1, 1'b0, STATUS_OK},
      '{CMD_QUERY, SHEET_MAX, 14'd0, 14'd0, 20'd0, 20'd0, 14'd150, 20'd999,
        1'b1, 1'b0, STATUS_OK},
      '{CMD_QUERY, SHEET_MAX, 14'd0, 14'd0, 20'd0, 20'd0, 14'd150, 20'd2001,
        1'b1, 1'b0, STATUS_OK},
      // inverted columns, then inverted rows: stored but never hit
      '{CMD_ADD, 15'd5, 14'd300, 14'd200, 20'd0, 20'd10, 14'd0, 20'd0, 1'b1, 1'b0, STATUS_OK},
      '{CMD_QUERY, 15'd5, 14'd0, 14'd0, 20'd0, 20'd0, 14'd250, 20'd5, 1'b1, 1'b0, STATUS_OK},
      '{CMD_ADD, 15'd6, 14'd0, 14'd10, 20'd50, 20'd40, 14'd0, 20'd0, 1'b1, 1'b0, STATUS_OK},
      '{CMD_QUERY, 15'd6, 14'd0, 14'd0, 20'd0, 20'd0, 14'd5, 20'd45, 1'b1, 1'b0, STATUS_OK},
      // single cell at the far corner
      '{CMD_ADD, 15'd7, COL_MAX, COL_MAX, ROW_MAX, ROW_MAX, 14'd0, 20'd0,
        1'b1, 1'b0, STATUS_OK},
      '{CMD_QUERY, 15'd7, 14'd0, 14'd0, 20'd0, 20'd0, COL_MAX, ROW_MAX,
        1'b1, 1'b1, STATUS_OK},
      '{CMD_QUERY, 15'd7, 14'd0, 14'd0, 20'd0, 20'd0, COL_MAX - 14'd1, ROW_MAX,
        1'b0, 1'b0, STATUS_OK},
      // rectangle fields on a query and point fields on an add are ignored
      '{CMD_QUERY, SHEET_MAX, COL_MAX, COL_MAX, ROW_MAX, ROW_MAX, 14'd150, 20'd1500,
        1'b1, 1'b1, STATUS_OK},
      '{CMD_ADD, 15'h2AAA, 14'h1555, 14'h2AAA, 20'h55555, 20'hAAAAA, COL_MAX, ROW_MAX,
        1'b0, 1'b0, STATUS_OK},
      '{CMD_QUERY, 15'h2AAA, 14'h2AAA, 14'h1555, 20'hAAAAA, 20'h55555, 14'h2000, 20'h80000,
        1'b0, 1'b0, STATUS_OK}
    };

    // Hold reset, then release it on a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_words[i]) offer_word(directed_words[i]);
    // Adds are rare, so the table fills part way through and the
    // table-full refusals show up in the later part of the run.
    repeat (NUM_RANDOM) offer_word(random_word());
    in_valid <= 1'b0;

    // Drain: wait for every pending answer, then watch for stray results.
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Receiver: stall in random runs; once, hold off for a long stretch so
  // the block backs up and stalls its input while words keep coming.
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    hold_value = 1'b0;
    pressure_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!pressure_done && words_accepted >= 500) begin
        pressure_done = 1'b1;
        out_stall <= 1'b1;
        for (int n = 0; n < PRESSURE_CYCLES; n++) @(negedge clk);
        hold_left = 0;
      end
      if (hold_left == 0) begin
        case ($urandom_range(0, 99)) inside
          [0:54]:  begin hold_value = 1'b0; hold_left = $urandom_range(1, 8); end
          [55:84]: begin hold_value = 1'b1; hold_left = $urandom_range(1, 3); end
          [85:92]: begin hold_value = 1'b1; hold_left = $urandom_range(8, 30); end
          default: begin hold_value = 1'b0; hold_left = $urandom_range(50, 200); end
        endcase
      end
      out_stall <= hold_value;
      hold_left--;
      @(negedge clk);
    end
  end

  // Check each accepted result against the oldest pending answer.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        flag_mismatch("result with no word pending, hit", hit, 1'bx);
      end else begin
        oldest = pending_answers.pop_front();
        if (hit !== oldest.hit) flag_mismatch("hit", hit, oldest.hit);
        if (status !== oldest.status) flag_mismatch("status", status, oldest.status);
      end
      results_seen++;
    end
  end

endmodule

`default_nettype wire
